// File: sv/encoder_position_speed_calc_macros.svh
// ----------------------------------------------------------------------------
// Encoder position/speed calc: assertion macros
// Concurrent assertion shorthands. The clock and reset are clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef ENCODER_POSITION_SPEED_CALC_MACROS_SVH
`define ENCODER_POSITION_SPEED_CALC_MACROS_SVH

// same-cycle implication
`define EPSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EPSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/epsc_pkg.sv
// ----------------------------------------------------------------------------
// Encoder position/speed calc: package
// Shared constants, register codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package epsc_pkg;

  localparam int EPSC_FRAC_BITS = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic [15:0] CNT_RECIP_RST = 16'd16776;
  localparam logic [4:0]  POLE_CNT_RST  = 5'd2;
  localparam logic [15:0] ZERO_OFS_RST  = 16'd0;
  localparam logic [15:0] PER_NUMER_RST = 16'd125;
  localparam logic [15:0] RATED_RPM_RST = 16'd6000;

  // product bits kept for a Q15 angle (mask 0x03FFF000, shifted down by 11)
  localparam int ANGLE_MSB = 25;
  localparam int ANGLE_LSB = 12;

  localparam logic [15:0] OVF_PERIOD = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CNT_RECIP = 3'd0,
    CFG_POLE_CNT  = 3'd1,
    CFG_ZERO_OFS  = 3'd2,
    CFG_PER_NUMER = 3'd3,
    CFG_RATED_RPM = 3'd4
  } epsc_cfg_e;

  typedef struct packed {
    logic capture;
    logic angle;
    logic track;
    logic rpm_fr;
    logic div_step;
    logic rpm_pr;
    logic load_out;
  } epsc_cmd_t;

  typedef struct packed {
    logic div_last;
  } epsc_status_t;

endpackage

// File: sv/epsc_in_if.sv
// ----------------------------------------------------------------------------
// Encoder position/speed calc: input channel
// One encoder counter snapshot per beat.
// ----------------------------------------------------------------------------
interface epsc_in_if;
  logic        valid;
  logic        ready;
  logic        direction_forward;
  logic [15:0] position_count;
  logic        unit_timeout;
  logic [15:0] latched_count;
  logic        unit_pos_event;
  logic        capture_overflow;
  logic [15:0] capture_period;

  modport source (
    output valid, direction_forward, position_count, unit_timeout, latched_count,
           unit_pos_event, capture_overflow, capture_period,
    input  ready
  );

  modport sink (
    input  valid, direction_forward, position_count, unit_timeout, latched_count,
           unit_pos_event, capture_overflow, capture_period,
    output ready
  );

  modport mon (
    input valid, ready, direction_forward, position_count, unit_timeout, latched_count,
          unit_pos_event, capture_overflow, capture_period
  );
endinterface

// File: sv/epsc_out_if.sv
// ----------------------------------------------------------------------------
// Encoder position/speed calc: result channel
// Angles and held speeds, one beat per input beat.
// ----------------------------------------------------------------------------
interface epsc_out_if;
  logic               valid;
  logic               ready;
  logic [14:0]        theta_mech;
  logic [14:0]        theta_elec;
  logic signed [25:0] speed_fr_pu;
  logic signed [16:0] speed_fr_rpm;
  logic [24:0]        speed_pr_pu;
  logic signed [16:0] speed_pr_rpm;

  modport source (
    output valid, theta_mech, theta_elec, speed_fr_pu, speed_fr_rpm, speed_pr_pu,
           speed_pr_rpm,
    input  ready
  );

  modport sink (
    input  valid, theta_mech, theta_elec, speed_fr_pu, speed_fr_rpm, speed_pr_pu,
           speed_pr_rpm,
    output ready
  );

  modport mon (
    input valid, ready, theta_mech, theta_elec, speed_fr_pu, speed_fr_rpm, speed_pr_pu,
          speed_pr_rpm
  );
endinterface

// File: sv/epsc_ctrl.sv
// ----------------------------------------------------------------------------
// Encoder position/speed calc: controller
// Sequences one snapshot through angle, tracking, divide and rpm steps and
// owns both handshakes.
// ----------------------------------------------------------------------------
module epsc_ctrl
  import epsc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  epsc_status_t status_i,
  output epsc_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_TRACK,
    ST_RPMFR,
    ST_DIV,
    ST_RPMPR,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_ANGLE;
        end
      end
      ST_ANGLE: begin
        cmd_o.angle = 1'b1;
        state_d     = ST_TRACK;
      end
      ST_TRACK: begin
        cmd_o.track = 1'b1;
        state_d     = ST_RPMFR;
      end
      ST_RPMFR: begin
        cmd_o.rpm_fr = 1'b1;
        state_d      = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_RPMPR;
        end
      end
      ST_RPMPR: begin
        cmd_o.rpm_pr = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: sv/epsc_dp.sv
// ----------------------------------------------------------------------------
// Encoder position/speed calc: datapath
// Config registers, angle products, wrapped position difference, restoring
// divider for the period speed, rpm products and the output register.
// ----------------------------------------------------------------------------
module epsc_dp
  import epsc_pkg::*;
#(
  parameter int FRAC_BITS = EPSC_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  epsc_cmd_t             cmd_i,
  output epsc_status_t          status_o,
  input  logic                  direction_forward_i,
  input  logic [15:0]           position_count_i,
  input  logic                  unit_timeout_i,
  input  logic [15:0]           latched_count_i,
  input  logic                  unit_pos_event_i,
  input  logic                  capture_overflow_i,
  input  logic [15:0]           capture_period_i,
  output logic [14:0]           theta_mech_o,
  output logic [14:0]           theta_elec_o,
  output logic signed [25:0]    speed_fr_pu_o,
  output logic signed [16:0]    speed_fr_rpm_o,
  output logic [24:0]           speed_pr_pu_o,
  output logic signed [16:0]    speed_pr_rpm_o
);

  localparam int CntW = $clog2(FRAC_BITS);
  localparam logic [CntW-1:0] CntLast = CntW'(FRAC_BITS - 1);
  // 2^FRAC_BITS; in FRAC_BITS+1 bits adding it also serves as subtracting it
  localparam logic [FRAC_BITS:0] OnePu = {1'b1, {FRAC_BITS{1'b0}}};

  // configuration
  logic [15:0] mech_q, cal_q, sscal_q, base_q;
  logic [4:0]  pp_q;

  // captured snapshot
  logic        fwd_q, tmo_q, upe_q, ovf_q;
  logic [15:0] pos_q, lat_q, per_in_q;

  // working registers
  logic [14:0]          tmech_q, telec_q;
  logic [FRAC_BITS-1:0] npos_q, prev_q;
  logic signed [FRAC_BITS:0] held_fr_q;
  logic signed [16:0]   rpm_fr_q, rpm_pr_q;
  logic [FRAC_BITS:0]   held_pr_q;

  // divider
  logic [15:0]          per_q, rem_q;
  logic                 sat_q;
  logic [FRAC_BITS-1:0] quot_q;
  logic [CntW-1:0]      cnt_q;

  // output register
  logic [14:0]        o_tmech_q, o_telec_q;
  logic signed [25:0] o_fr_pu_q;
  logic signed [16:0] o_fr_rpm_q, o_pr_rpm_q;
  logic [24:0]        o_pr_pu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mech_q  <= CNT_RECIP_RST;
      pp_q    <= POLE_CNT_RST;
      cal_q   <= ZERO_OFS_RST;
      sscal_q <= PER_NUMER_RST;
      base_q  <= RATED_RPM_RST;
    end else if (cfg_we_i) begin
      case (epsc_cfg_e'(cfg_idx_i))
        CFG_CNT_RECIP: mech_q  <= cfg_wdata_i;
        CFG_POLE_CNT:  pp_q    <= cfg_wdata_i[4:0];
        CFG_ZERO_OFS:  cal_q   <= cfg_wdata_i;
        CFG_PER_NUMER: sscal_q <= cfg_wdata_i;
        CFG_RATED_RPM: base_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // angle products
  logic [15:0] raw;
  logic [31:0] prod_a, prod_b;
  assign raw    = 16'(pos_q + cal_q);
  assign prod_a = 32'(raw) * 32'(mech_q);
  assign prod_b = 32'(lat_q) * 32'(mech_q);

  // electrical angle and wrapped position difference
  logic [19:0]               telec_full;
  logic signed [FRAC_BITS:0] diff, fr_new;
  logic                      wrap;
  assign telec_full = 20'(pp_q) * 20'(tmech_q);
  assign diff   = $signed({1'b0, npos_q}) - $signed({1'b0, prev_q});
  assign wrap   = fwd_q ? diff[FRAC_BITS] : (!diff[FRAC_BITS] && (diff != '0));
  assign fr_new = wrap ? (diff + $signed(OnePu)) : diff;

  // rpm from position difference: floor is an arithmetic shift
  logic signed [FRAC_BITS+17:0] fr_prod;
  assign fr_prod = $signed({1'b0, base_q}) * held_fr_q;

  // divider step
  logic [16:0] rem2;
  logic        ge;
  assign rem2 = {rem_q, 1'b0};
  assign ge   = (rem2 >= {1'b0, per_q});

  // period speed, saturated at one, and its rpm
  logic [FRAC_BITS:0]    s_fin;
  logic [FRAC_BITS+16:0] pr_prod;
  logic [16:0]           pr_rpm;
  assign s_fin   = sat_q ? OnePu : {1'b0, quot_q};
  assign pr_prod = (FRAC_BITS+17)'(s_fin) * (FRAC_BITS+17)'(base_q);
  assign pr_rpm  = pr_prod[FRAC_BITS+16:FRAC_BITS];

  // held values resized to the field widths
  logic signed [63:0] fr_ext;
  logic [63:0]        pr_ext;
  assign fr_ext = 64'(held_fr_q);
  assign pr_ext = 64'(held_pr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      held_fr_q <= '0;
      rpm_fr_q  <= '0;
      held_pr_q <= '0;
      rpm_pr_q  <= '0;
    end else begin
      if (cmd_i.track && tmo_q) begin
        held_fr_q <= fr_new;
        prev_q    <= npos_q;
      end
      if (cmd_i.rpm_fr && tmo_q) begin
        rpm_fr_q <= fr_prod[FRAC_BITS+16:FRAC_BITS];
      end
      if (cmd_i.rpm_pr && upe_q) begin
        held_pr_q <= s_fin;
        rpm_pr_q  <= fwd_q ? $signed(pr_rpm) : $signed(17'd0 - pr_rpm);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      fwd_q    <= direction_forward_i;
      pos_q    <= position_count_i;
      tmo_q    <= unit_timeout_i;
      lat_q    <= latched_count_i;
      upe_q    <= unit_pos_event_i;
      ovf_q    <= capture_overflow_i;
      per_in_q <= capture_period_i;
    end
    if (cmd_i.angle) begin
      tmech_q <= {prod_a[ANGLE_MSB:ANGLE_LSB], 1'b0};
      npos_q  <= {prod_b[ANGLE_MSB:ANGLE_LSB], 1'b0, {(FRAC_BITS-15){1'b0}}};
      per_q   <= ovf_q ? OVF_PERIOD : per_in_q;
      rem_q   <= sscal_q;
      // scaler >= period means a quotient of at least one (zero period too)
      sat_q   <= (sscal_q >= (ovf_q ? OVF_PERIOD : per_in_q));
      quot_q  <= '0;
      cnt_q   <= CntLast;
    end
    if (cmd_i.track) begin
      telec_q <= telec_full[14:0];
    end
    if (cmd_i.div_step) begin
      rem_q  <= ge ? 16'(rem2 - {1'b0, per_q}) : rem2[15:0];
      quot_q <= {quot_q[FRAC_BITS-2:0], ge};
      cnt_q  <= cnt_q - CntW'(1);
    end
    if (cmd_i.load_out) begin
      o_tmech_q  <= tmech_q;
      o_telec_q  <= telec_q;
      o_fr_pu_q  <= fr_ext[25:0];
      o_fr_rpm_q <= rpm_fr_q;
      o_pr_pu_q  <= pr_ext[24:0];
      o_pr_rpm_q <= rpm_pr_q;
    end
  end

  assign status_o.div_last = (cnt_q == '0);

  assign theta_mech_o   = o_tmech_q;
  assign theta_elec_o   = o_telec_q;
  assign speed_fr_pu_o  = o_fr_pu_q;
  assign speed_fr_rpm_o = o_fr_rpm_q;
  assign speed_pr_pu_o  = o_pr_pu_q;
  assign speed_pr_rpm_o = o_pr_rpm_q;

endmodule

// File: sv/encoder_position_speed_calc.sv
// ----------------------------------------------------------------------------
// Encoder position/speed calc: top level
// Q15 mechanical/electrical angle and held position-difference and
// period-based speeds from one encoder counter snapshot per beat.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  in_i     in   valid/ready          encoder snapshot
//  out_o    out  valid/ready          angles and held speeds
//  cfg      in   cfg_we_i, no ready   cfg_idx_i, cfg_wdata_i
//
//  A result is loaded into the output register after the angle, tracking,
//  rpm, divide and period-rpm steps; the next beat is taken after that load,
//  so one item at a time, paced by the one-bit-per-cycle restoring divider.
//  Reset is asynchronous, active low, and restores config registers and held speeds.
//  A result stalled on out_o stays in the output register while the next
//  item is taken and worked on; that item then waits until the register frees.
// ----------------------------------------------------------------------------
module encoder_position_speed_calc
  import epsc_pkg::*;
#(
  parameter int FRAC_BITS = EPSC_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  epsc_in_if.sink               in_i,
  epsc_out_if.source            out_o
);

  epsc_cmd_t    cmd;
  epsc_status_t status;

  epsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  epsc_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .cmd_i               (cmd),
    .status_o            (status),
    .direction_forward_i (in_i.direction_forward),
    .position_count_i    (in_i.position_count),
    .unit_timeout_i      (in_i.unit_timeout),
    .latched_count_i     (in_i.latched_count),
    .unit_pos_event_i    (in_i.unit_pos_event),
    .capture_overflow_i  (in_i.capture_overflow),
    .capture_period_i    (in_i.capture_period),
    .theta_mech_o        (out_o.theta_mech),
    .theta_elec_o        (out_o.theta_elec),
    .speed_fr_pu_o       (out_o.speed_fr_pu),
    .speed_fr_rpm_o      (out_o.speed_fr_rpm),
    .speed_pr_pu_o       (out_o.speed_pr_pu),
    .speed_pr_rpm_o      (out_o.speed_pr_rpm)
  );

endmodule

// File: sv/epsc_chk.sv
// ----------------------------------------------------------------------------
// Encoder position/speed calc: port checker
// Watches the in_i and out_o channels over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "encoder_position_speed_calc_macros.svh"

module epsc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [14:0] theta_mech_i,
  input logic [14:0] theta_elec_i,
  input logic [25:0] speed_fr_pu_i,
  input logic [16:0] speed_fr_rpm_i,
  input logic [24:0] speed_pr_pu_i,
  input logic [16:0] speed_pr_rpm_i
);

  logic         in_fire, out_stall;
  logic [114:0] out_pay;
  assign in_fire   = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;
  assign out_pay   = {theta_mech_i, theta_elec_i, speed_fr_pu_i, speed_fr_rpm_i,
                      speed_pr_pu_i, speed_pr_rpm_i};

  // one item at a time: a taken beat closes the input until it is done
  `EPSC_ASSERT_NXT(a_busy_after_accept, in_fire, !in_ready_i, "input open after accept")

  // a stalled result holds
  `EPSC_ASSERT_NXT(a_out_hold, out_stall, out_valid_i && $stable(out_pay), "stalled result changed")

  // angles come from a product shifted with its low bit dropped: always even
  `EPSC_ASSERT_IMP(a_even_angles, out_valid_i, !theta_mech_i[0] && !theta_elec_i[0], "odd angle")

endmodule

bind encoder_position_speed_calc epsc_chk u_epsc_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .theta_mech_i   (out_o.theta_mech),
  .theta_elec_i   (out_o.theta_elec),
  .speed_fr_pu_i  (out_o.speed_fr_pu),
  .speed_fr_rpm_i (out_o.speed_fr_rpm),
  .speed_pr_pu_i  (out_o.speed_pr_pu),
  .speed_pr_rpm_i (out_o.speed_pr_rpm)
);
